FILE: rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, codes and constants of the MIPS32 subset execute block.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Data memory size in bytes and the layout of its four byte banks.
    localparam int MEM_BYTES = 65536;
    localparam int MEM_ROWS  = (MEM_BYTES + 3) / 4;
    localparam int ROW_W     = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;

    // Depth of the result queue; it also bounds the items in flight.
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 136;

    localparam logic [31:0] PC_RESET    = 32'h0040_0000;
    localparam logic [31:0] SP_RESET    = 32'h7fff_effc;
    localparam logic [31:0] GP_RESET    = 32'h1000_8000;
    localparam logic [31:0] REGION_MASK = 32'hF000_0000;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_GP   = 5'd28;
    localparam logic [4:0] REG_SP   = 5'd29;
    localparam logic [4:0] REG_RA   = 5'd31;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_AND  = 5'd2,
        OP_OR   = 5'd3,
        OP_NOR  = 5'd4,
        OP_SLT  = 5'd5,
        OP_ADDI = 5'd6,
        OP_ANDI = 5'd7,
        OP_ORI  = 5'd8,
        OP_LW   = 5'd9,
        OP_SW   = 5'd10,
        OP_BEQ  = 5'd11,
        OP_BNE  = 5'd12,
        OP_J    = 5'd13,
        OP_JAL  = 5'd14,
        OP_JR   = 5'd15,
        OP_NOP  = 5'd16
    } op_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  written_index;
        logic [31:0] written_value;
        logic        store_done;
        logic [31:0] store_address;
        logic [31:0] store_value;
        logic        out_of_range;
    } result_t;

    // Value of a register that has not been written since reset.
    function automatic logic [31:0] rf_reset_value(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            REG_SP:  val = SP_RESET;
            REG_GP:  val = GP_RESET;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/mips_subset_execute_top.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_top
// Executes one decoded MIPS32 subset instruction per item and reports the
// next PC, the register write and any store.
// ----------------------------------------------------------------------------
// The block takes one instruction item per clock while s_tready is high and
// returns one result item for each. Each item reads the register file as it
// is accepted, executes and addresses the data memory in the next cycle, and
// completes its register write and leaves for the result queue in the cycle
// after that; the loaded word is forwarded straight into the operands of the
// following item, so dependent items still issue back to back. The data
// memory is four synchronous byte banks with one read and one write port
// each, so an unaligned word moves in a single access. After reset the memory
// is cleared one row of four bytes per cycle, which holds s_tready low until
// all MEM_ROWS (16384) rows are cleared. A queue of four results lets items
// keep coming while a finished result waits to be taken.
module mips_subset_execute_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action, src_reg, second_reg, dest_reg, imm16, jump_index (lowest first)
    input  logic [mse_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // next_pc, reg_written, written_index, written_value, store_done,
    // store_address, store_value, out_of_range (lowest first)
    output logic [mse_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mse_pkg::*;

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic        s_accept;
    logic [4:0]  in_action;
    logic [4:0]  in_rs;
    logic [4:0]  in_rt;
    logic [4:0]  in_rd;
    logic [15:0] in_imm;
    logic [25:0] in_jidx;

    assign s_accept  = s_tvalid && s_tready;
    assign in_action = s_tdata[4:0];
    assign in_rs     = s_tdata[9:5];
    assign in_rt     = s_tdata[14:10];
    assign in_rd     = s_tdata[19:15];
    assign in_imm    = s_tdata[35:20];
    assign in_jidx   = s_tdata[61:36];

    // ------------------------------------------------------------------
    // Register file: two read ports with registered data, one write port
    // ------------------------------------------------------------------
    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic        rf_wen;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    logic        ex_valid_reg;
    op_t         ex_op_reg;
    logic [4:0]  ex_rs_reg;
    logic [4:0]  ex_rt_reg;
    logic [4:0]  ex_rd_reg;
    logic [15:0] ex_imm_reg;
    logic [25:0] ex_jidx_reg;
    logic [31:0] ex_a_raw_reg;
    logic [31:0] ex_b_raw_reg;

    always_ff @(posedge aclk) begin
        if (rf_wen) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        // A write in the same cycle as the read is passed straight through.
        if (s_accept) begin
            if (rf_wen && rf_waddr == in_rs) begin
                ex_a_raw_reg <= rf_wdata;
            end else if (rf_valid_reg[in_rs]) begin
                ex_a_raw_reg <= rf_mem[in_rs];
            end else begin
                ex_a_raw_reg <= rf_reset_value(in_rs);
            end
            if (rf_wen && rf_waddr == in_rt) begin
                ex_b_raw_reg <= rf_wdata;
            end else if (rf_valid_reg[in_rt]) begin
                ex_b_raw_reg <= rf_mem[in_rt];
            end else begin
                ex_b_raw_reg <= rf_reset_value(in_rt);
            end
            ex_op_reg   <= op_t'(in_action);
            ex_rs_reg   <= in_rs;
            ex_rt_reg   <= in_rt;
            ex_rd_reg   <= in_rd;
            ex_imm_reg  <= in_imm;
            ex_jidx_reg <= in_jidx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (rf_wen) begin
            rf_valid_reg[rf_waddr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Execute stage
    // ------------------------------------------------------------------
    logic [31:0] pc_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] simm;
    logic [31:0] zimm;
    logic [31:0] pc_plus4;
    logic [31:0] pc_plus8;
    logic [31:0] br_target;
    logic [31:0] j_target;
    logic [31:0] ea;
    logic        addr_ok;
    logic        ex_wr;
    logic [4:0]  ex_widx;
    logic [31:0] ex_wval;
    logic [31:0] ex_npc;
    logic        ex_is_load;
    logic        ex_is_store;
    logic        ex_reg_written;
    result_t     ex_res;

    logic          mem_valid_reg;
    result_t       mem_res_reg;
    logic          mem_load_reg;
    logic [1:0]    mem_off_reg;
    result_t       mem_final;

    // The item one stage ahead writes back at the end of this cycle.
    assign op_a = (rf_wen && rf_waddr == ex_rs_reg) ? rf_wdata : ex_a_raw_reg;
    assign op_b = (rf_wen && rf_waddr == ex_rt_reg) ? rf_wdata : ex_b_raw_reg;

    assign simm      = {{16{ex_imm_reg[15]}}, ex_imm_reg};
    assign zimm      = {16'h0000, ex_imm_reg};
    assign pc_plus4  = pc_reg + 32'd4;
    assign pc_plus8  = pc_reg + 32'd8;
    assign br_target = pc_plus4 + {simm[29:0], 2'b00};
    assign j_target  = (pc_plus4 & REGION_MASK) | {4'h0, ex_jidx_reg, 2'b00};
    assign ea        = op_a + simm;
    assign addr_ok   = ({1'b0, ea} + 33'd3) < 33'(MEM_BYTES);

    always_comb begin
        ex_wr       = 1'b0;
        ex_widx     = REG_ZERO;
        ex_wval     = '0;
        ex_npc      = pc_plus4;
        ex_is_load  = 1'b0;
        ex_is_store = 1'b0;
        case (ex_op_reg)
            OP_ADD: begin
                ex_wr = 1'b1; ex_widx = ex_rd_reg; ex_wval = op_a + op_b;
            end
            OP_SUB: begin
                ex_wr = 1'b1; ex_widx = ex_rd_reg; ex_wval = op_a - op_b;
            end
            OP_AND: begin
                ex_wr = 1'b1; ex_widx = ex_rd_reg; ex_wval = op_a & op_b;
            end
            OP_OR: begin
                ex_wr = 1'b1; ex_widx = ex_rd_reg; ex_wval = op_a | op_b;
            end
            OP_NOR: begin
                ex_wr = 1'b1; ex_widx = ex_rd_reg; ex_wval = ~(op_a | op_b);
            end
            OP_SLT: begin
                ex_wr   = 1'b1;
                ex_widx = ex_rd_reg;
                ex_wval = {31'd0, $signed(op_a) < $signed(op_b)};
            end
            OP_ADDI: begin
                ex_wr = 1'b1; ex_widx = ex_rt_reg; ex_wval = op_a + simm;
            end
            OP_ANDI: begin
                ex_wr = 1'b1; ex_widx = ex_rt_reg; ex_wval = op_a & zimm;
            end
            OP_ORI: begin
                ex_wr = 1'b1; ex_widx = ex_rt_reg; ex_wval = op_a | zimm;
            end
            OP_LW: begin
                ex_wr = 1'b1; ex_widx = ex_rt_reg; ex_is_load = 1'b1;
            end
            OP_SW: begin
                ex_is_store = 1'b1;
            end
            OP_BEQ: begin
                if (op_a == op_b) begin
                    ex_npc = br_target;
                end
            end
            OP_BNE: begin
                if (op_a != op_b) begin
                    ex_npc = br_target;
                end
            end
            OP_J: begin
                ex_npc = j_target;
            end
            OP_JAL: begin
                ex_wr = 1'b1; ex_widx = REG_RA; ex_wval = pc_plus8; ex_npc = j_target;
            end
            OP_JR: begin
                ex_npc = op_a;
            end
            default: begin
                ex_wr = 1'b0;
            end
        endcase
    end

    assign ex_reg_written = ex_wr && (ex_widx != REG_ZERO);

    always_comb begin
        ex_res.next_pc       = ex_npc;
        ex_res.reg_written   = ex_reg_written;
        ex_res.written_index = ex_reg_written ? ex_widx : REG_ZERO;
        ex_res.written_value = ex_reg_written ? ex_wval : '0;
        ex_res.store_done    = ex_is_store && addr_ok;
        ex_res.store_address = (ex_is_store && addr_ok) ? ea : '0;
        ex_res.store_value   = (ex_is_store && addr_ok) ? op_b : '0;
        ex_res.out_of_range  = (ex_is_load || ex_is_store) && !addr_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_RESET;
        end else if (ex_valid_reg) begin
            pc_reg <= ex_npc;
        end
    end

    // ------------------------------------------------------------------
    // Data memory: four byte banks, byte k of a row holds address 4*row+k
    // ------------------------------------------------------------------
    logic             clr_busy_reg;
    logic [ROW_W-1:0] clr_row_reg;
    logic [ROW_W-1:0] ea_row;
    logic             st_we;
    logic             bank_we    [4];
    logic [ROW_W-1:0] bank_waddr [4];
    logic [ROW_W-1:0] bank_raddr [4];
    logic [7:0]       bank_wdata [4];
    logic [7:0]       bank_q_reg [4];

    assign ea_row = ea[ROW_W+1:2];
    assign st_we  = ex_valid_reg && ex_is_store && addr_ok;

    always_comb begin
        logic [1:0] sel;
        sel = 2'd0;
        for (int k = 0; k < 4; k++) begin
            // Byte position within the big-endian word that lands in bank k.
            sel           = 2'(k) - ea[1:0];
            bank_raddr[k] = ea_row + ROW_W'(2'(k) < ea[1:0]);
            bank_we[k]    = clr_busy_reg || st_we;
            bank_waddr[k] = clr_busy_reg ? clr_row_reg : bank_raddr[k];
            bank_wdata[k] = clr_busy_reg ? 8'h00 : op_b[{2'd3 - sel, 3'b000} +: 8];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] bank_mem [MEM_ROWS];
        always_ff @(posedge aclk) begin
            if (bank_we[k]) begin
                bank_mem[bank_waddr[k]] <= bank_wdata[k];
            end
            bank_q_reg[k] <= bank_mem[bank_raddr[k]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_row_reg <= clr_row_reg + ROW_W'(1);
            if (clr_row_reg == ROW_W'(MEM_ROWS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Write-back stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg <= 1'b0;
        end else begin
            mem_valid_reg <= ex_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else begin
            ex_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_valid_reg) begin
            mem_res_reg  <= ex_res;
            mem_load_reg <= ex_is_load && addr_ok && ex_reg_written;
            mem_off_reg  <= ea[1:0];
        end
    end

    always_comb begin
        logic [31:0] load_word;
        for (int j = 0; j < 4; j++) begin
            load_word[8*(3-j) +: 8] = bank_q_reg[2'(mem_off_reg + 2'(j))];
        end
        mem_final = mem_res_reg;
        if (mem_load_reg) begin
            mem_final.written_value = load_word;
        end
    end

    assign rf_wen   = mem_valid_reg && mem_final.reg_written;
    assign rf_waddr = mem_final.written_index;
    assign rf_wdata = mem_final.written_value;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t          fifo_mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0] fifo_wr_ptr_reg;
    logic [PTR_W-1:0] fifo_rd_ptr_reg;
    logic [CNT_W-1:0] fifo_cnt_reg;
    logic [CNT_W-1:0] fifo_cnt_next;
    logic             fifo_push;
    logic             fifo_pop;
    logic [CNT_W:0]   in_flight;
    result_t          out_res;

    assign fifo_push = mem_valid_reg;
    assign fifo_pop  = m_tvalid && m_tready;

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push && !fifo_pop) begin
            fifo_cnt_next = fifo_cnt_reg + CNT_W'(1);
        end else if (fifo_pop && !fifo_push) begin
            fifo_cnt_next = fifo_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
            fifo_cnt_reg    <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (fifo_push) begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + PTR_W'(1);
            end
            if (fifo_pop) begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_push) begin
            fifo_mem_reg[fifo_wr_ptr_reg] <= mem_final;
        end
    end

    // Every item in the pipeline already has a place reserved in the queue.
    assign in_flight = {1'b0, fifo_cnt_reg} + (CNT_W+1)'(ex_valid_reg)
                     + (CNT_W+1)'(mem_valid_reg);
    assign s_tready  = !clr_busy_reg && (in_flight < (CNT_W+1)'(OUT_DEPTH));

    assign out_res  = fifo_mem_reg[fifo_rd_ptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {out_res.out_of_range,
                       out_res.store_value,
                       out_res.store_address,
                       out_res.store_done,
                       out_res.written_value,
                       out_res.written_index,
                       out_res.reg_written,
                       out_res.next_pc};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight <= (CNT_W+1)'(OUT_DEPTH))
        else $error("more items in flight than the result queue can hold");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> (fifo_cnt_reg < CNT_W'(OUT_DEPTH)) || fifo_pop)
        else $error("result pushed into a full queue");

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready && !ex_valid_reg && !st_we)
        else $error("item active while the data memory is being cleared");

    a_no_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wen |-> rf_waddr != REG_ZERO)
        else $error("write to register zero");

    a_pc_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ex_valid_reg |=> $stable(pc_reg))
        else $error("program counter moved without an item");

endmodule

FILE: sim/mse_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_exec_checker
// Watches both channels of the MIPS32 subset execute block, predicts every
// result item from its own copy of the PC, register file and data memory,
// and compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mse_exec_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // action, src_reg, second_reg, dest_reg, imm16, jump_index (lowest first)
    input  logic [mse_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // next_pc, reg_written, written_index, written_value, store_done,
    // store_address, store_value, out_of_range (lowest first)
    input  logic [mse_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             pending
);
    import mse_pkg::*;

    localparam int MA_W = $clog2(MEM_BYTES);

    logic [31:0] model_pc;
    logic [31:0] model_gpr [32];
    logic [7:0]  model_mem [MEM_BYTES];
    result_t     results_due [$];
    int          err_cnt = 0;

    // Executes one instruction item against the local state and returns the
    // result item the block should produce for it.
    task automatic execute_instr(input logic [S_TDATA_W-1:0] word, output result_t res);
        logic [4:0]      act;
        logic [4:0]      rs;
        logic [4:0]      rt;
        logic [4:0]      rd;
        logic [15:0]     imm;
        logic [25:0]     jidx;
        logic [31:0]     simm;
        logic [31:0]     a;
        logic [31:0]     b;
        logic [31:0]     seq_pc;
        logic [31:0]     ea;
        logic [MA_W-1:0] ma;
        logic [32:0]     last_byte;
        logic            in_mem;

        act  = word[4:0];
        rs   = word[9:5];
        rt   = word[14:10];
        rd   = word[19:15];
        imm  = word[35:20];
        jidx = word[61:36];
        simm = {{16{imm[15]}}, imm};
        a    = model_gpr[rs];
        b    = model_gpr[rt];
        seq_pc = model_pc + 32'd4;
        ea   = a + simm;
        ma   = ea[MA_W-1:0];
        // The bound is checked on the address of the last byte, without wrap.
        last_byte = {1'b0, ea} + 33'd3;
        in_mem = (last_byte < 33'(MEM_BYTES));

        res = '0;
        res.next_pc = seq_pc;
        case (act)
            OP_ADD: begin
                res.reg_written = 1'b1; res.written_index = rd; res.written_value = a + b;
            end
            OP_SUB: begin
                res.reg_written = 1'b1; res.written_index = rd; res.written_value = a - b;
            end
            OP_AND: begin
                res.reg_written = 1'b1; res.written_index = rd; res.written_value = a & b;
            end
            OP_OR: begin
                res.reg_written = 1'b1; res.written_index = rd; res.written_value = a | b;
            end
            OP_NOR: begin
                res.reg_written = 1'b1; res.written_index = rd; res.written_value = ~(a | b);
            end
            OP_SLT: begin
                res.reg_written = 1'b1; res.written_index = rd;
                res.written_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            end
            OP_ADDI: begin
                res.reg_written = 1'b1; res.written_index = rt; res.written_value = a + simm;
            end
            OP_ANDI: begin
                res.reg_written = 1'b1; res.written_index = rt;
                res.written_value = a & {16'h0000, imm};
            end
            OP_ORI: begin
                res.reg_written = 1'b1; res.written_index = rt;
                res.written_value = a | {16'h0000, imm};
            end
            OP_LW: begin
                res.reg_written = 1'b1;
                res.written_index = rt;
                if (in_mem) begin
                    res.written_value = {model_mem[ma], model_mem[ma + MA_W'(1)],
                                         model_mem[ma + MA_W'(2)], model_mem[ma + MA_W'(3)]};
                end else begin
                    res.out_of_range = 1'b1;
                end
            end
            OP_SW: begin
                if (in_mem) begin
                    model_mem[ma]            = b[31:24];
                    model_mem[ma + MA_W'(1)] = b[23:16];
                    model_mem[ma + MA_W'(2)] = b[15:8];
                    model_mem[ma + MA_W'(3)] = b[7:0];
                    res.store_done    = 1'b1;
                    res.store_address = ea;
                    res.store_value   = b;
                end else begin
                    res.out_of_range = 1'b1;
                end
            end
            OP_BEQ: begin
                if (a == b) res.next_pc = seq_pc + (simm << 2);
            end
            OP_BNE: begin
                if (a != b) res.next_pc = seq_pc + (simm << 2);
            end
            OP_J: begin
                res.next_pc = {seq_pc[31:28], jidx, 2'b00};
            end
            OP_JAL: begin
                res.reg_written = 1'b1; res.written_index = REG_RA;
                res.written_value = model_pc + 32'd8;
                res.next_pc = {seq_pc[31:28], jidx, 2'b00};
            end
            OP_JR: begin
                res.next_pc = a;
            end
            default: begin
                // NOP and the unused codes change nothing but the PC.
            end
        endcase

        if (res.reg_written && res.written_index != REG_ZERO) begin
            model_gpr[res.written_index] = res.written_value;
        end else begin
            res.reg_written   = 1'b0;
            res.written_index = '0;
            res.written_value = '0;
        end
        model_pc = res.next_pc;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;

        if (!aresetn) begin
            model_pc = PC_RESET;
            foreach (model_gpr[i]) model_gpr[i] = '0;
            model_gpr[REG_SP] = SP_RESET;
            model_gpr[REG_GP] = GP_RESET;
            foreach (model_mem[i]) model_mem[i] = 8'h00;
            results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    err_cnt++;
                end else begin
                    want = results_due.pop_front();
                    got.next_pc       = m_tdata[31:0];
                    got.reg_written   = m_tdata[32];
                    got.written_index = m_tdata[37:33];
                    got.written_value = m_tdata[69:38];
                    got.store_done    = m_tdata[70];
                    got.store_address = m_tdata[102:71];
                    got.store_value   = m_tdata[134:103];
                    got.out_of_range  = m_tdata[135];
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("reg_written", 32'(want.reg_written),
                                32'(got.reg_written));
                    check_field("written_index", 32'(want.written_index),
                                32'(got.written_index));
                    check_field("written_value", want.written_value, got.written_value);
                    check_field("store_done", 32'(want.store_done), 32'(got.store_done));
                    check_field("store_address", want.store_address, got.store_address);
                    check_field("store_value", want.store_value, got.store_value);
                    check_field("out_of_range", 32'(want.out_of_range),
                                32'(got.out_of_range));
                end
            end
            if (s_tvalid && s_tready) begin
                execute_instr(s_tdata, want);
                results_due.push_back(want);
            end
        end
        fail_count <= err_cnt;
        pending    <= results_due.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives instruction items into the MIPS32 subset execute block: a directed
// pass over every operation and corner, then random items that are mostly
// base-register set-ups followed by loads and stores around that base.
// ----------------------------------------------------------------------------
module tb;
    import mse_pkg::*;

    localparam int          RANDOM_ITEMS = 1800;
    localparam logic [4:0]  ACT_UNUSED   = 5'd31;

    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    int                     fail_count;
    int                     pending;

    int                     burst_left = 0;
    int                     items_sent = 0;
    ready_mode_t            ready_mode = RDY_ALWAYS;
    int                     mode_left = 0;
    logic [2:0]             stall_tick = '0;

    always #5 aclk = ~aclk;

    mips_subset_execute_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mse_exec_checker exec_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver switches between stretches of steady, patchy and periodic
    // readiness.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        stall_tick <= stall_tick + 3'd1;
        case (ready_mode)
            RDY_ALWAYS:  m_tready <= 1'b1;
            RDY_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY:  m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= stall_tick[2];
        endcase
    end

    // Sends one instruction item; the sender idles between bursts.
    task automatic send_instr(input logic [4:0] act, input logic [4:0] rs,
                              input logic [4:0] rt, input logic [4:0] rd,
                              input logic [15:0] imm, input logic [25:0] jidx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, jidx, imm, rd, rt, rs, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Loads a base register with ORI, then loads and stores around that base.
    task automatic mem_sequence();
        logic [4:0]  base_reg;
        logic [15:0] base;
        logic [15:0] offs;
        logic [4:0]  act;
        int          region;
        int          n;
        base_reg = 5'($urandom_range(1, 31));
        region = $urandom_range(0, 9);
        if (region < 7) base = 16'($urandom_range(0, 255));
        else if (region < 8) base = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        else base = 16'($urandom);
        send_instr(OP_ORI, REG_ZERO, base_reg, 5'($urandom), base, 26'($urandom));
        n = $urandom_range(1, 5);
        repeat (n) begin
            act = $urandom_range(0, 1) ? OP_SW : OP_LW;
            if ($urandom_range(0, 4) == 0) offs = 16'($urandom);
            else offs = 16'($urandom_range(0, 16) - 8);
            send_instr(act, base_reg, 5'($urandom), 5'($urandom), offs, 26'($urandom));
        end
    endtask

    initial begin
        logic [4:0] act;
        int         random_end;
        int         next_drain;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part; r28 and r29 hold their reset values at the start.
        send_instr(OP_ADD,  REG_SP,   REG_GP,   5'd1,     16'h0000, 26'h0);
        send_instr(OP_SUB,  REG_ZERO, REG_SP,   5'd2,     16'h0000, 26'h0);
        send_instr(OP_AND,  REG_SP,   REG_GP,   5'd3,     16'h0000, 26'h0);
        send_instr(OP_OR,   REG_SP,   REG_GP,   5'd4,     16'h0000, 26'h0);
        send_instr(OP_NOR,  REG_ZERO, REG_ZERO, 5'd5,     16'h0000, 26'h0);
        send_instr(OP_SLT,  5'd5,     REG_ZERO, 5'd6,     16'h0000, 26'h0);
        send_instr(OP_SLT,  REG_ZERO, 5'd5,     5'd7,     16'h0000, 26'h0);
        send_instr(OP_ADDI, REG_ZERO, 5'd8,     5'd0,     16'hFFFF, 26'h0);
        send_instr(OP_ANDI, 5'd5,     5'd9,     5'd0,     16'hFFFF, 26'h0);
        send_instr(OP_ORI,  REG_ZERO, 5'd10,    5'd0,     16'h8000, 26'h0);
        // A write to register zero is dropped.
        send_instr(OP_ADD,  REG_SP,   REG_GP,   REG_ZERO, 16'h0000, 26'h0);
        // The last word that fits in memory, then the first ones that do not.
        send_instr(OP_ORI,  REG_ZERO, 5'd11,    5'd0,     16'hFFFC, 26'h0);
        send_instr(OP_SW,   5'd11,    5'd5,     5'd0,     16'h0000, 26'h0);
        send_instr(OP_LW,   5'd11,    5'd12,    5'd0,     16'h0001, 26'h0);
        send_instr(OP_SW,   5'd11,    REG_SP,   5'd0,     16'h0001, 26'h0);
        // Unaligned store and an overlapping load.
        send_instr(OP_SW,   REG_ZERO, REG_SP,   5'd0,     16'h0001, 26'h0);
        send_instr(OP_LW,   REG_ZERO, 5'd13,    5'd0,     16'h0000, 26'h0);
        // A negative offset from zero lands near the top of the address space.
        send_instr(OP_LW,   REG_ZERO, 5'd14,    5'd0,     16'hFFFC, 26'h0);
        send_instr(OP_BEQ,  REG_ZERO, REG_ZERO, 5'd0,     16'hFFFF, 26'h0);
        send_instr(OP_BNE,  REG_ZERO, REG_ZERO, 5'd0,     16'h7FFF, 26'h0);
        send_instr(OP_BNE,  5'd5,     REG_ZERO, 5'd0,     16'h0000, 26'h0);
        // Moving the PC high shows that jumps keep the region of pc + 4.
        send_instr(OP_JR,   REG_SP,   REG_ZERO, 5'd0,     16'h0000, 26'h0);
        send_instr(OP_J,    REG_ZERO, REG_ZERO, 5'd0,     16'h0000, 26'h3FFFFFF);
        send_instr(OP_JAL,  REG_ZERO, REG_ZERO, 5'd0,     16'h0000, 26'h0);
        send_instr(OP_JR,   REG_RA,   REG_ZERO, 5'd0,     16'h0000, 26'h0);
        send_instr(OP_NOP,  5'd31,    5'd31,    5'd31,    16'hFFFF, 26'h3FFFFFF);
        send_instr(ACT_UNUSED, 5'd5,  5'd5,     5'd5,     16'h1234, 26'h0);
        wait_drained();

        random_end = items_sent + RANDOM_ITEMS;
        next_drain = items_sent + $urandom_range(300, 500);
        while (items_sent < random_end) begin
            if (items_sent >= next_drain) begin
                wait_drained();
                next_drain = items_sent + $urandom_range(300, 500);
            end
            if ($urandom_range(0, 99) < 55) begin
                mem_sequence();
            end else begin
                if ($urandom_range(0, 9) == 0) act = 5'($urandom_range(0, 31));
                else act = 5'($urandom_range(OP_ADD, OP_JR));
                send_instr(act, 5'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                           26'($urandom));
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // The watchdog leaves room for the memory clear after reset.
    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
